FILE: rtl/tlb_pkg.sv
package tlb_pkg;

  localparam int TABLE_SIZE = 32;
  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int PAGE_SHIFT = 12;
  localparam int VPN_W = 20;
  localparam int PFN_W = 20;
  localparam logic [15:0] LFSR_RESET = 16'hACE1;

  typedef enum logic [1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_WRITE_IDX = 2'd1,
    REQ_WRITE_RND = 2'd2,
    REQ_FLUSH     = 2'd3
  } req_t;

  localparam logic [1:0] ACC_READ  = 2'd0;
  localparam logic [1:0] ACC_WRITE = 2'd1;
  localparam logic [1:0] ACC_EXEC  = 2'd2;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_MODIFIED = 2'd1;
  localparam logic [1:0] FAULT_LOAD     = 2'd2;
  localparam logic [1:0] FAULT_STORE    = 2'd3;

  typedef struct packed {
    logic [VPN_W-1:0] vpn;
    logic [PFN_W-1:0] pfn;
    logic             dirty;
    logic             rd;
    logic             wr;
    logic             ex;
  } entry_t;

  typedef struct packed {
    logic                  active;
    logic                  found;
    logic [VPN_W-1:0]      vpn;
    logic [PAGE_SHIFT-1:0] offset;
    logic [1:0]            kind;
    logic [1:0]            fault;
    logic [31:0]           phys;
  } probe_t;

  typedef struct packed {
    logic   flush;
    logic   valid;
    entry_t data;
  } wr_cmd_t;

endpackage

FILE: rtl/tlb_cell.sv
module tlb_cell
  import tlb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  wr_cmd_t wr_cmd,
  input  logic    sel,
  input  probe_t  probe_in,
  output probe_t  probe_out
);

  entry_t entry;
  logic   valid;
  probe_t probe_next;
  logic   ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_cmd.flush) begin
      valid <= 1'b0;
    end else if (sel) begin
      valid <= wr_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      entry <= wr_cmd.data;
    end
  end

  always_comb begin
    case (probe_in.kind)
      ACC_READ:  ok = entry.rd;
      ACC_WRITE: ok = entry.wr;
      ACC_EXEC:  ok = entry.ex;
      default:   ok = 1'b0;
    endcase
  end

  always_comb begin
    probe_next = probe_in;
    if (probe_in.active && !probe_in.found && valid && entry.vpn == probe_in.vpn) begin
      probe_next.found = 1'b1;
      probe_next.phys = '0;
      if (probe_in.kind == ACC_WRITE && !entry.dirty) begin
        probe_next.fault = FAULT_MODIFIED;
      end else if (!ok) begin
        probe_next.fault = (probe_in.kind == ACC_WRITE) ? FAULT_STORE : FAULT_LOAD;
      end else begin
        probe_next.fault = FAULT_NONE;
        probe_next.phys = {entry.pfn, probe_in.offset};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

FILE: rtl/tlb_address_translation_core.sv
// Channel   Signals                                          Direction
// request   start, busy, req_type, vaddr, access_kind,       in (busy out)
//           entry_index, entry_vpn, entry_pfn, entry_* flags
// result    done, paddr, fault_code, direct_mapped,          out
//           slot_written
// An entry write, a flush or a direct-region translate gives its result in the cycle after the transfer.
// A table lookup walks the row of 32 entry cells one cell per cycle; its result is registered
// after the last cell, and busy stays high until the probe leaves the last cell.
// Synchronous reset invalidates every entry and loads the random slot generator.
// The receiver cannot stall: each result is shown for one cycle with done high.
module tlb_address_translation_core
  import tlb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] vaddr,
  input  logic [1:0]  access_kind,
  input  logic [5:0]  entry_index,
  input  logic [19:0] entry_vpn,
  input  logic [19:0] entry_pfn,
  input  logic        entry_valid,
  input  logic        entry_dirty,
  input  logic        entry_readable,
  input  logic        entry_writable,
  input  logic        entry_executable,
  output logic        done,
  output logic [31:0] paddr,
  output logic [1:0]  fault_code,
  output logic        direct_mapped,
  output logic [5:0]  slot_written
);

  logic              accept;
  logic              is_direct;
  logic              lookup_go;
  logic [15:0]       lfsr;
  logic [15:0]       lfsr_next;
  logic [SLOT_W-1:0] wr_slot;
  logic              wr_en;
  logic [TABLE_SIZE-1:0] sel;
  wr_cmd_t           wr_cmd;
  probe_t            chain [TABLE_SIZE+1];
  probe_t            last;

  assign accept    = start && !busy;
  assign is_direct = (vaddr[31:30] == 2'b10);
  assign lookup_go = accept && req_t'(req_type) == REQ_TRANSLATE && !is_direct;
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};

  always_comb begin
    wr_slot = '0;
    wr_en   = 1'b0;
    case (req_t'(req_type))
      REQ_WRITE_IDX: begin
        wr_en   = accept && ({1'b0, entry_index} < 7'(TABLE_SIZE));
        wr_slot = entry_index[SLOT_W-1:0];
      end
      REQ_WRITE_RND: begin
        wr_en   = accept;
        wr_slot = SLOT_W'(lfsr_next % 16'(TABLE_SIZE));
      end
      default: begin
        wr_en   = 1'b0;
        wr_slot = '0;
      end
    endcase
  end

  always_comb begin
    wr_cmd.flush      = accept && req_t'(req_type) == REQ_FLUSH;
    wr_cmd.valid      = entry_valid;
    wr_cmd.data.vpn   = entry_vpn;
    wr_cmd.data.pfn   = entry_pfn;
    wr_cmd.data.dirty = entry_dirty;
    wr_cmd.data.rd    = entry_readable;
    wr_cmd.data.wr    = entry_writable;
    wr_cmd.data.ex    = entry_executable;
  end

  always_comb begin
    chain[0].active = lookup_go;
    chain[0].found  = 1'b0;
    chain[0].vpn    = vaddr[31:PAGE_SHIFT];
    chain[0].offset = vaddr[PAGE_SHIFT-1:0];
    chain[0].kind   = access_kind;
    chain[0].fault  = (access_kind == ACC_WRITE) ? FAULT_STORE : FAULT_LOAD;
    chain[0].phys   = '0;
  end

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    assign sel[i] = wr_en && (wr_slot == SLOT_W'(i));
    tlb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_cmd    (wr_cmd),
      .sel       (sel[i]),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

  assign last = chain[TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_RESET;
    end else if (accept && req_t'(req_type) == REQ_WRITE_RND) begin
      lfsr <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (lookup_go) begin
        busy <= 1'b1;
      end else if (last.active) begin
        busy <= 1'b0;
      end
      done <= (accept && !lookup_go) || last.active;
    end
  end

  always_ff @(posedge clk) begin
    if (last.active) begin
      paddr         <= last.phys;
      fault_code    <= last.fault;
      direct_mapped <= 1'b0;
      slot_written  <= '0;
    end else if (accept) begin
      fault_code <= FAULT_NONE;
      if (req_t'(req_type) == REQ_TRANSLATE) begin
        paddr         <= {2'b00, vaddr[29:0]};
        direct_mapped <= 1'b1;
        slot_written  <= '0;
      end else begin
        paddr         <= '0;
        direct_mapped <= 1'b0;
        slot_written  <= wr_en ? 6'(wr_slot) : '0;
      end
    end
  end

endmodule

FILE: rtl/tlb_checker.sv
module tlb_checker
  import tlb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  req_type,
  input logic [31:0] vaddr,
  input logic        done,
  input logic [31:0] paddr,
  input logic [1:0]  fault_code,
  input logic        direct_mapped,
  input logic [5:0]  slot_written
);

  a_table_op_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type != REQ_TRANSLATE |=> done && !busy)
    else $error("table operation result missing");

  a_direct_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_TRANSLATE && vaddr[31:30] == 2'b10
    |=> done && direct_mapped && fault_code == FAULT_NONE)
    else $error("direct translate result wrong");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_TRANSLATE && vaddr[31:30] != 2'b10
    |=> busy && !done)
    else $error("lookup did not hold busy");

  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    done && fault_code != FAULT_NONE |-> paddr == '0 && !direct_mapped
    && slot_written == '0)
    else $error("faulted result carries data");

  a_direct_clean: assert property (@(posedge clk) disable iff (rst)
    done && direct_mapped |-> slot_written == '0 && paddr[31:30] == 2'b00)
    else $error("direct result inconsistent");

endmodule

bind tlb_address_translation_core tlb_checker u_tlb_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .req_type      (req_type),
  .vaddr         (vaddr),
  .done          (done),
  .paddr         (paddr),
  .fault_code    (fault_code),
  .direct_mapped (direct_mapped),
  .slot_written  (slot_written)
);

FILE: dv/testbench.sv
module testbench;
  import tlb_pkg::*;

  localparam logic [31:0] DIRECT_BASE = 32'h8000_0000;
  localparam logic [31:0] DIRECT_END  = 32'hC000_0000;
  localparam logic [1:0]  ACC_UNDEF   = 2'd3;
  localparam logic [4:0]  FLAGS_ALL   = 5'b11111;
  localparam int          RANDOM_OPS  = 1300;
  localparam int          POOL_SIZE   = 8;

  typedef struct packed {
    req_t        kind;
    logic [31:0] va;
    logic [1:0]  acc;
    logic [5:0]  idx;
    logic [19:0] vpn;
    logic [19:0] pfn;
    logic        v;
    logic        d;
    logic        r;
    logic        w;
    logic        x;
    logic        drain;
  } tlb_op_t;

  typedef struct packed {
    logic        valid;
    logic [19:0] vpn;
    logic [19:0] pfn;
    logic        dirty;
    logic        rd;
    logic        wr;
    logic        ex;
  } page_slot_t;

  typedef struct packed {
    logic [31:0] phys;
    logic [1:0]  fault;
    logic        direct;
    logic [5:0]  slot;
  } xlat_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [31:0] vaddr = '0;
  logic [1:0]  access_kind = '0;
  logic [5:0]  entry_index = '0;
  logic [19:0] entry_vpn = '0;
  logic [19:0] entry_pfn = '0;
  logic        entry_valid = 1'b0;
  logic        entry_dirty = 1'b0;
  logic        entry_readable = 1'b0;
  logic        entry_writable = 1'b0;
  logic        entry_executable = 1'b0;
  logic        done;
  logic [31:0] paddr;
  logic [1:0]  fault_code;
  logic        direct_mapped;
  logic [5:0]  slot_written;

  page_slot_t  page_tab [TABLE_SIZE];
  logic [15:0] slot_lfsr;
  logic [19:0] page_pool [POOL_SIZE];
  tlb_op_t     pending_ops [$];
  xlat_res_t   expected_res [$];
  tlb_op_t     cur_op;
  xlat_res_t   oldest_res;
  int          accepted = 0;
  int          errors = 0;

  tlb_address_translation_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .vaddr(vaddr),
    .access_kind(access_kind),
    .entry_index(entry_index),
    .entry_vpn(entry_vpn),
    .entry_pfn(entry_pfn),
    .entry_valid(entry_valid),
    .entry_dirty(entry_dirty),
    .entry_readable(entry_readable),
    .entry_writable(entry_writable),
    .entry_executable(entry_executable),
    .done(done),
    .paddr(paddr),
    .fault_code(fault_code),
    .direct_mapped(direct_mapped),
    .slot_written(slot_written)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic page_slot_t slot_from_op(tlb_op_t op);
    page_slot_t s;
    s.valid = op.v;
    s.vpn   = op.vpn;
    s.pfn   = op.pfn;
    s.dirty = op.d;
    s.rd    = op.r;
    s.wr    = op.w;
    s.ex    = op.x;
    return s;
  endfunction

  function automatic xlat_res_t translate_and_update(tlb_op_t op);
    xlat_res_t   res;
    logic        hit;
    logic        allowed;
    logic [15:0] nxt;
    int          slot;
    res = '0;
    case (op.kind)
      REQ_TRANSLATE: begin
        if (op.va >= DIRECT_BASE && op.va < DIRECT_END) begin
          res.phys = op.va - DIRECT_BASE;
          res.direct = 1'b1;
        end else begin
          res.fault = (op.acc == ACC_WRITE) ? FAULT_STORE : FAULT_LOAD;
          hit = 1'b0;
          for (int i = 0; i < TABLE_SIZE && !hit; i++) begin
            if (page_tab[i].valid && page_tab[i].vpn == op.va[31:12]) begin
              hit = 1'b1;
              case (op.acc)
                ACC_READ:  allowed = page_tab[i].rd;
                ACC_WRITE: allowed = page_tab[i].wr;
                ACC_EXEC:  allowed = page_tab[i].ex;
                default:   allowed = 1'b0;
              endcase
              if (op.acc == ACC_WRITE && !page_tab[i].dirty) begin
                res.fault = FAULT_MODIFIED;
              end else if (allowed) begin
                res.fault = FAULT_NONE;
                res.phys = {page_tab[i].pfn, op.va[11:0]};
              end
            end
          end
        end
      end
      REQ_WRITE_IDX: begin
        if (op.idx < TABLE_SIZE) begin
          page_tab[op.idx[SLOT_W-1:0]] = slot_from_op(op);
          res.slot = op.idx;
        end
      end
      REQ_WRITE_RND: begin
        nxt = {slot_lfsr[0] ^ slot_lfsr[2] ^ slot_lfsr[3] ^ slot_lfsr[5], slot_lfsr[15:1]};
        slot_lfsr = nxt;
        slot = nxt % TABLE_SIZE;
        page_tab[slot[SLOT_W-1:0]] = slot_from_op(op);
        res.slot = slot[5:0];
      end
      default: begin
        for (int i = 0; i < TABLE_SIZE; i++) page_tab[i] = '0;
      end
    endcase
    return res;
  endfunction

  function automatic tlb_op_t noisy_op();
    tlb_op_t op;
    op.kind  = req_t'($urandom_range(0, 3));
    op.va    = $urandom;
    op.acc   = 2'($urandom_range(0, 3));
    op.idx   = 6'($urandom);
    op.vpn   = 20'($urandom);
    op.pfn   = 20'($urandom);
    op.v     = ($urandom_range(0, 99) < 85);
    op.d     = 1'($urandom);
    op.r     = 1'($urandom);
    op.w     = 1'($urandom);
    op.x     = 1'($urandom);
    op.drain = 1'b0;
    return op;
  endfunction

  task automatic add_lookup(logic [31:0] va, logic [1:0] acc);
    tlb_op_t op;
    op = noisy_op();
    op.kind = REQ_TRANSLATE;
    op.va = va;
    op.acc = acc;
    pending_ops.push_back(op);
  endtask

  task automatic add_fill(req_t k, logic [5:0] idx, logic [19:0] vpn, logic [19:0] pfn,
                          logic [4:0] flags);
    tlb_op_t op;
    op = noisy_op();
    op.kind = k;
    op.idx = idx;
    op.vpn = vpn;
    op.pfn = pfn;
    {op.v, op.d, op.r, op.w, op.x} = flags;
    pending_ops.push_back(op);
  endtask

  task automatic add_flush();
    tlb_op_t op;
    op = noisy_op();
    op.kind = REQ_FLUSH;
    op.drain = 1'b1;
    pending_ops.push_back(op);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // The transfer happens at an edge with start high and busy low; the next request is chosen at
  // that same edge, but start drops when the queue is empty, a drain waits or an idle gap is drawn.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_res.push_back(translate_and_update(cur_op));
        accepted++;
      end
      if (!start || !busy) begin
        if (pending_ops.size() == 0 ||
            (pending_ops[0].drain && expected_res.size() != 0) ||
            (!(accepted >= 500 && accepted < 800) && $urandom_range(0, 99) < 26)) begin
          start <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          start <= 1'b1;
          req_type <= cur_op.kind;
          vaddr <= cur_op.va;
          access_kind <= cur_op.acc;
          entry_index <= cur_op.idx;
          entry_vpn <= cur_op.vpn;
          entry_pfn <= cur_op.pfn;
          entry_valid <= cur_op.v;
          entry_dirty <= cur_op.d;
          entry_readable <= cur_op.r;
          entry_writable <= cur_op.w;
          entry_executable <= cur_op.x;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result, phys %h fault %0d direct %0d slot %0d",
                 $time, paddr, fault_code, direct_mapped, slot_written);
        errors++;
      end else begin
        oldest_res = expected_res.pop_front();
        check_field("paddr", oldest_res.phys, paddr);
        check_field("fault_code", 32'(oldest_res.fault), 32'(fault_code));
        check_field("direct_mapped", 32'(oldest_res.direct), 32'(direct_mapped));
        check_field("slot_written", 32'(oldest_res.slot), 32'(slot_written));
      end
    end
  end

  initial begin
    tlb_op_t op;
    int      roll;
    int      sel;
    for (int i = 0; i < TABLE_SIZE; i++) page_tab[i] = '0;
    slot_lfsr = LFSR_RESET;
    for (int i = 0; i < POOL_SIZE; i++) begin
      page_pool[i] = 20'($urandom);
      if (page_pool[i][19:18] == 2'b10) page_pool[i][18] = 1'b1;
    end

    add_lookup(32'h0000_0000, ACC_READ);
    add_lookup(32'hFFFF_FFFF, ACC_WRITE);
    add_lookup(32'h1234_5678, ACC_EXEC);
    add_lookup(32'h8000_0000, ACC_READ);
    add_lookup(32'hBFFF_FFFF, ACC_WRITE);
    add_lookup(32'h7FFF_FFFF, ACC_READ);
    add_lookup(32'hC000_0000, ACC_EXEC);
    add_fill(REQ_WRITE_IDX, 6'd0, 20'hFFFFF, 20'hFFFFF, FLAGS_ALL);
    add_lookup(32'hFFFF_FABC, ACC_READ);
    add_lookup(32'hFFFF_F000, ACC_UNDEF);
    add_fill(REQ_WRITE_IDX, 6'(TABLE_SIZE - 1), 20'h00000, 20'h12345, 5'b10110);
    add_lookup(32'h0000_0123, ACC_WRITE);
    add_lookup(32'h0000_0FFF, ACC_EXEC);
    add_fill(REQ_WRITE_IDX, 6'(TABLE_SIZE), 20'h00000, 20'h00000, FLAGS_ALL);
    add_fill(REQ_WRITE_IDX, 6'd63, 20'h00000, 20'h00000, FLAGS_ALL);
    add_lookup(32'h0000_0123, ACC_READ);
    add_fill(REQ_WRITE_IDX, 6'd3, 20'h00001, 20'hAAAAA, 5'b01111);
    add_fill(REQ_WRITE_IDX, 6'd5, 20'h00001, 20'h55555, 5'b11001);
    add_fill(REQ_WRITE_IDX, 6'd7, 20'h00001, 20'h0F0F0, FLAGS_ALL);
    add_lookup(32'h0000_1800, ACC_READ);
    add_lookup(32'h0000_1800, ACC_WRITE);
    add_lookup(32'h0000_1800, ACC_EXEC);
    add_fill(REQ_WRITE_RND, 6'd0, 20'hABCDE, 20'h13579, FLAGS_ALL);
    add_fill(REQ_WRITE_RND, 6'd0, 20'h00000, 20'hFFFFF, FLAGS_ALL);
    add_lookup(32'hABCD_E001, ACC_READ);
    add_flush();
    add_lookup(32'hFFFF_F000, ACC_READ);

    // Mostly lookups into a small page pool so that hits, duplicate pages and
    // permission faults are common; full-range addresses add noise.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      op = noisy_op();
      roll = $urandom_range(0, 99);
      sel = $urandom_range(0, 99);
      if (roll < 55) begin
        op.kind = REQ_TRANSLATE;
        if (sel < 15) begin
          op.va = $urandom_range(DIRECT_BASE, DIRECT_END - 1);
        end else if (sel < 85) begin
          op.va = {page_pool[$urandom_range(0, POOL_SIZE - 1)], op.va[11:0]};
        end
      end else if (roll < 97) begin
        op.kind = (roll < 77) ? REQ_WRITE_IDX : REQ_WRITE_RND;
        if ($urandom_range(0, 4) != 0) op.idx = 6'($urandom_range(0, TABLE_SIZE - 1));
        if (sel < 85) op.vpn = page_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        op.kind = REQ_FLUSH;
      end
      op.drain = (n % 250 == 125);
      pending_ops.push_back(op);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || start || expected_res.size() != 0) @(negedge clk);
    repeat (TABLE_SIZE + 4) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
